FILE: hdl/mbtcp_pkg.sv
// mbtcp_pkg: shared types, constants and helper functions for the register server
// used by mbtcp_ctrl, mbtcp_dp and modbus_tcp_register_server_core
`timescale 1ns / 1ps

package mbtcp_pkg;

  // default size of the holding register file
  localparam int unsigned RegCountDef = 32;

  // frame layout
  localparam logic [3:0] FullLen     = 4'd12;
  localparam logic [7:0] FcRead      = 8'd3;
  localparam logic [7:0] FcWrite     = 8'd6;

  // response pair positions
  localparam logic [5:0] PairTid     = 6'd0;
  localparam logic [5:0] PairProto   = 6'd1;
  localparam logic [5:0] PairLen     = 6'd2;
  localparam logic [5:0] PairUnit    = 6'd3;
  localparam logic [5:0] PairData    = 6'd4;
  localparam logic [5:0] PairWrLast  = 6'd5;

  // fixed length field of a write response and header length of a read response
  localparam logic [15:0] WrRespLen  = 16'd6;
  localparam logic [15:0] RdHdrLen   = 16'd3;

  // reset values of the holding registers
  localparam logic [15:0] Reg0Reset  = 16'd100;
  localparam logic [15:0] Reg1Reset  = 16'd250;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // request byte accepted
    logic clr_idx;  // start a new response
    logic wr_en;    // write the addressed holding register
    logic rd_en;    // fetch the next holding register
    logic emit;     // load one pair into the output register
    logic rd_kind;  // 1: read response, 0: write response
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_ok;
    logic wr_ok;
    logic out_free;
    logic last_pair;
  } dp_stat_t;

  function automatic logic [15:0] reg_reset_val(input int unsigned idx);
    logic [15:0] val;
    val = '0;
    if (idx == 0) val = Reg0Reset;
    if (idx == 1) val = Reg1Reset;
    return val;
  endfunction

endpackage

FILE: hdl/mbtcp_ctrl.sv
// mbtcp_ctrl: sequencer for intake, request check and response emission
// depends on mbtcp_pkg
`timescale 1ns / 1ps

module mbtcp_ctrl
  import mbtcp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     frame_end_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   kind_q, kind_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    cmd_o         = '0;
    cmd_o.rd_kind = kind_q;
    in_stall_o    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (frame_end_i) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.rd_ok) begin
          kind_d        = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d       = S_FETCH;
        end else if (stat_i.wr_ok) begin
          kind_d        = 1'b0;
          cmd_o.clr_idx = 1'b1;
          cmd_o.wr_en   = 1'b1;
          state_d       = S_FETCH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.last_pair ? S_IDLE : S_FETCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTH
  // a pair is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("pair emitted into a full output register");

  // a register write always starts a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |=> state_q == S_FETCH)
    else $error("write not followed by its response");

  // an intermediate pair is always followed by another fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && stat_i.out_free && !stat_i.last_pair) |=> state_q == S_FETCH)
    else $error("response ended early");
`endif

endmodule

FILE: hdl/mbtcp_dp.sv
// mbtcp_dp: request field capture, holding register file and response pair output
// depends on mbtcp_pkg
`timescale 1ns / 1ps

module mbtcp_dp
  import mbtcp_pkg::*;
#(
  parameter int unsigned RegCount = RegCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [7:0] first_byte_o,
  output logic [7:0] second_byte_o,
  output logic [1:0] valid_bytes_o,
  output logic       last_o
);

  localparam int unsigned AddrW = $clog2(RegCount);
  localparam logic [16:0] RegCountW = 17'(RegCount);

  // parsed request fields
  logic [3:0]  pos_q;
  logic        full_q;
  logic [15:0] trans_id_q, proto_id_q, start_q, value_q;
  logic [7:0]  unit_id_q, func_q;
  logic [3:0]  pos_inc;

  // holding registers and fetch path
  logic [15:0] regs_q [RegCount];
  logic [15:0] rd_q;
  logic [7:0]  prev_lo_q;
  logic [5:0]  idx_q;
  logic [15:0] rd_addr;

  // output register
  logic       out_valid_q;
  logic [7:0] first_q, second_q;
  logic [1:0] vbytes_q;
  logic       last_q;

  // response derived values
  logic [15:0] resp_len;
  logic [7:0]  byte_cnt;
  logic [7:0]  first_d, second_d;

  assign pos_inc = (pos_q < FullLen) ? pos_q + 4'd1 : pos_q;

  // byte capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      full_q     <= 1'b0;
      trans_id_q <= '0;
      proto_id_q <= '0;
      unit_id_q  <= '0;
      func_q     <= '0;
      start_q    <= '0;
      value_q    <= '0;
    end else if (cmd_i.capture) begin
      case (pos_q)
        4'd0:    trans_id_q[15:8] <= rx_byte_i;
        4'd1:    trans_id_q[7:0]  <= rx_byte_i;
        4'd2:    proto_id_q[15:8] <= rx_byte_i;
        4'd3:    proto_id_q[7:0]  <= rx_byte_i;
        4'd6:    unit_id_q        <= rx_byte_i;
        4'd7:    func_q           <= rx_byte_i;
        4'd8:    start_q[15:8]    <= rx_byte_i;
        4'd9:    start_q[7:0]     <= rx_byte_i;
        4'd10:   value_q[15:8]    <= rx_byte_i;
        4'd11:   value_q[7:0]     <= rx_byte_i;
        default: ;
      endcase
      if (frame_end_i) begin
        pos_q  <= '0;
        full_q <= (pos_inc == FullLen);
      end else begin
        pos_q <= pos_inc;
      end
    end
  end

  // request checks, output register state and last pair detection
  always_comb begin
    stat_o.rd_ok = full_q && (proto_id_q == '0) && (func_q == FcRead) &&
                   ({1'b0, start_q} + {1'b0, value_q} <= RegCountW);
    stat_o.wr_ok = full_q && (proto_id_q == '0) && (func_q == FcWrite) &&
                   ({1'b0, start_q} < RegCountW);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
    stat_o.last_pair = cmd_i.rd_kind ? (idx_q == PairData + value_q[5:0])
                                     : (idx_q == PairWrLast);
  end

  // register file with fixed reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < RegCount; i++) regs_q[i] <= reg_reset_val(i);
    end else if (cmd_i.wr_en) begin
      regs_q[start_q[AddrW-1:0]] <= value_q;
    end
  end

  assign rd_addr = start_q + {10'd0, idx_q} - {10'd0, PairData};

  // register fetch and pair counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.clr_idx) begin
      idx_q <= '0;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= ({1'b0, rd_addr} < RegCountW) ? regs_q[rd_addr[AddrW-1:0]] : '0;
    end
    if (cmd_i.emit) prev_lo_q <= rd_q[7:0];
  end

  assign resp_len = cmd_i.rd_kind ? RdHdrLen + {value_q[14:0], 1'b0} : WrRespLen;
  assign byte_cnt = {value_q[6:0], 1'b0};

  // pair selection
  always_comb begin
    first_d  = '0;
    second_d = '0;
    case (idx_q)
      PairTid: begin
        first_d  = trans_id_q[15:8];
        second_d = trans_id_q[7:0];
      end
      PairProto: ;
      PairLen: begin
        first_d  = resp_len[15:8];
        second_d = resp_len[7:0];
      end
      PairUnit: begin
        first_d  = unit_id_q;
        second_d = func_q;
      end
      PairData: begin
        first_d  = cmd_i.rd_kind ? byte_cnt : start_q[15:8];
        second_d = cmd_i.rd_kind ? rd_q[15:8] : start_q[7:0];
      end
      default: begin
        first_d  = cmd_i.rd_kind ? prev_lo_q : value_q[15:8];
        second_d = cmd_i.rd_kind ? rd_q[15:8] : value_q[7:0];
      end
    endcase
    // final pair of a read carries a single byte
    if (cmd_i.rd_kind && stat_o.last_pair) second_d = '0;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      first_q  <= first_d;
      second_q <= second_d;
      vbytes_q <= (cmd_i.rd_kind && stat_o.last_pair) ? 2'd1 : 2'd2;
      last_q   <= stat_o.last_pair;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign first_byte_o  = first_q;
  assign second_byte_o = second_q;
  assign valid_bytes_o = vbytes_q;
  assign last_o        = last_q;

endmodule

FILE: hdl/modbus_tcp_register_server_core.sv
// modbus_tcp_register_server_core: top level of the holding register server
// depends on mbtcp_pkg, mbtcp_ctrl and mbtcp_dp
//
//   channel   direction  handshake              payload
//   request   in         in_valid_i/in_stall_o   rx_byte_i, frame_end_i
//   response  out        out_valid_o/out_stall_i first_byte_o, second_byte_o,
//                                                valid_bytes_o, last_o
//
// request bytes are taken one per cycle while no response is in progress
// after the last byte of a frame the request is checked, then each
// response pair passes through a register fetch and then an output load
// a read of n registers answers in 5 + n pairs, a write in 6 pairs
// a stalled output register holds its pair and pauses the sequencer
// reset loads the register file at once, no clearing pass is needed
`timescale 1ns / 1ps

module modbus_tcp_register_server_core
  import mbtcp_pkg::*;
#(
  parameter int unsigned RegCount = RegCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] first_byte_o,
  output logic [7:0] second_byte_o,
  output logic [1:0] valid_bytes_o,
  output logic       last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  mbtcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  mbtcp_dp #(
    .RegCount (RegCount)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .frame_end_i   (frame_end_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .first_byte_o  (first_byte_o),
    .second_byte_o (second_byte_o),
    .valid_bytes_o (valid_bytes_o),
    .last_o        (last_o)
  );

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for the modbus tcp holding register server core
// depends on mbtcp_pkg and modbus_tcp_register_server_core; runs a directed request table,
// then random frames; checks every response pair against a built-in model or the table
`timescale 1ns / 1ps

module tb;
  import mbtcp_pkg::*;

  localparam int unsigned NumRegs    = RegCountDef;
  localparam int unsigned ByteTarget = 280;
  localparam int unsigned DrainLimit = 20000;
  localparam int unsigned TailCycles = 50;

  // how the expected reply of a request frame is obtained
  typedef enum logic [1:0] {
    BY_MODEL,
    NO_REPLY,
    ECHO_BACK,
    READ_BACK
  } reply_kind_e;

  // one request frame; the two data words are used by READ_BACK only
  typedef struct packed {
    logic [15:0] tid;
    logic [15:0] proto;
    logic [7:0]  unit;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] val;
    logic [3:0]  nb;
    reply_kind_e kind;
    logic [15:0] w0;
    logic [15:0] w1;
  } frame_t;

  // one response pair
  typedef struct packed {
    logic [7:0] fb;
    logic [7:0] sb;
    logic [1:0] nvalid;
    logic       fin;
  } pair_t;

  logic       clk = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] valid_bytes;
  logic       last_flag;

  // model state of the server
  logic [15:0] regs_q [NumRegs];
  logic [3:0]  pos_q = '0;
  logic [15:0] tid_q = '0;
  logic [15:0] proto_q = '0;
  logic [7:0]  unit_q = '0;
  logic [7:0]  fc_q = '0;
  logic [15:0] addr_q = '0;
  logic [15:0] val_q = '0;

  logic [7:0] reply_bytes [$];
  pair_t      frame_pairs [$];
  pair_t      due_pairs [$];

  int unsigned gap_pct = 7;
  int unsigned stall_pct = 7;
  int unsigned fails = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned pairs_seen = 0;
  int unsigned replies_seen = 0;

  // directed requests, walked in order straight after reset
  frame_t plan [22] = '{
    // reset contents of the first two registers
    '{16'h0000, 16'h0000, 8'h00, FcRead,  16'd0,     16'd2,     4'd12, READ_BACK, 16'd100, 16'd250},
    // whole file in one read, all-ones ids
    '{16'hFFFF, 16'h0000, 8'hFF, FcRead,  16'd0,     16'd32,    4'd12, BY_MODEL,  16'd0, 16'd0},
    // top register written with all ones, then bottom one with zero
    '{16'h1234, 16'h0000, 8'h01, FcWrite, 16'd31,    16'hFFFF,  4'd12, ECHO_BACK, 16'd0, 16'd0},
    '{16'h8000, 16'h0000, 8'h80, FcWrite, 16'd0,     16'h0000,  4'd12, ECHO_BACK, 16'd0, 16'd0},
    '{16'h0001, 16'h0000, 8'h7F, FcRead,  16'd30,    16'd2,     4'd12, READ_BACK, 16'h0000, 16'hFFFF},
    // zero count read right at the end of the file
    '{16'h00FF, 16'h0000, 8'h02, FcRead,  16'd32,    16'd0,     4'd12, READ_BACK, 16'd0, 16'd0},
    // reads and writes out of range, no wrap of start plus count
    '{16'h0F0F, 16'h0000, 8'h03, FcRead,  16'd31,    16'd2,     4'd12, NO_REPLY,  16'd0, 16'd0},
    '{16'hF0F0, 16'h0000, 8'h04, FcRead,  16'hFFFF,  16'hFFFF,  4'd12, NO_REPLY,  16'd0, 16'd0},
    '{16'h5555, 16'h0000, 8'h05, FcRead,  16'd0,     16'd33,    4'd12, NO_REPLY,  16'd0, 16'd0},
    '{16'hAAAA, 16'h0000, 8'h06, FcWrite, 16'd32,    16'h1234,  4'd12, NO_REPLY,  16'd0, 16'd0},
    '{16'h4321, 16'h0000, 8'h07, FcWrite, 16'hFFFF,  16'h5555,  4'd12, NO_REPLY,  16'd0, 16'd0},
    // failed writes leave register 0 as written above
    '{16'h0002, 16'h0000, 8'h08, FcRead,  16'd0,     16'd1,     4'd12, READ_BACK, 16'h0000, 16'd0},
    // wrong protocol id
    '{16'h0003, 16'h0001, 8'h09, FcRead,  16'd0,     16'd1,     4'd12, NO_REPLY,  16'd0, 16'd0},
    '{16'h0004, 16'h8000, 8'h0A, FcWrite, 16'd2,     16'h7777,  4'd12, NO_REPLY,  16'd0, 16'd0},
    // unknown function codes
    '{16'h0005, 16'h0000, 8'h0B, 8'h00,   16'd0,     16'd1,     4'd12, NO_REPLY,  16'd0, 16'd0},
    '{16'h0006, 16'h0000, 8'h0C, 8'hFF,   16'd0,     16'd1,     4'd12, NO_REPLY,  16'd0, 16'd0},
    // short frames
    '{16'h0007, 16'h0000, 8'h0D, FcWrite, 16'd3,     16'h3333,  4'd11, NO_REPLY,  16'd0, 16'd0},
    '{16'h0008, 16'h0000, 8'h0E, FcRead,  16'd0,     16'd1,     4'd1,  NO_REPLY,  16'd0, 16'd0},
    // trailing bytes beyond the pdu are dropped
    '{16'h0009, 16'h0000, 8'h0F, FcWrite, 16'd5,     16'hA55A,  4'd15, ECHO_BACK, 16'd0, 16'd0},
    '{16'h000A, 16'h0000, 8'h10, FcRead,  16'd4,     16'd2,     4'd13, BY_MODEL,  16'd0, 16'd0},
    '{16'h000B, 16'h0000, 8'h11, FcWrite, 16'd1,     16'h8001,  4'd12, BY_MODEL,  16'd0, 16'd0},
    '{16'h000C, 16'h0000, 8'h12, FcRead,  16'd0,     16'd3,     4'd12, BY_MODEL,  16'd0, 16'd0}
  };

  modbus_tcp_register_server_core #(
    .RegCount(NumRegs)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .rx_byte_i    (rx_byte),
    .frame_end_i  (frame_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .first_byte_o (first_byte),
    .second_byte_o(second_byte),
    .valid_bytes_o(valid_bytes),
    .last_o       (last_flag)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mbap header of a response
  function automatic void start_reply(input logic [15:0] tid, input logic [7:0] unit,
                                      input logic [15:0] len);
    reply_bytes.push_back(tid[15:8]);
    reply_bytes.push_back(tid[7:0]);
    reply_bytes.push_back(8'h00);
    reply_bytes.push_back(8'h00);
    reply_bytes.push_back(len[15:8]);
    reply_bytes.push_back(len[7:0]);
    reply_bytes.push_back(unit);
  endfunction

  // split the response bytes into pairs, odd tail padded with zero
  function automatic void pack_reply();
    pair_t p;
    for (int i = 0; i < reply_bytes.size(); i += 2) begin
      p.fb     = reply_bytes[i];
      p.sb     = (i + 1 < reply_bytes.size()) ? reply_bytes[i + 1] : 8'h00;
      p.nvalid = (i + 1 < reply_bytes.size()) ? 2'd2 : 2'd1;
      p.fin    = (i + 2 >= reply_bytes.size());
      frame_pairs.push_back(p);
    end
    reply_bytes.delete();
  endfunction

  // act on a complete request: register read or single register write
  function automatic void answer_request();
    int unsigned n;
    n = val_q;
    if (fc_q == FcRead) begin
      if (32'(addr_q) + n > NumRegs) return;
      start_reply(tid_q, unit_q, RdHdrLen + 16'(2 * n));
      reply_bytes.push_back(FcRead);
      reply_bytes.push_back(8'(2 * n));
      for (int i = 0; i < n; i++) begin
        reply_bytes.push_back(regs_q[32'(addr_q) + i][15:8]);
        reply_bytes.push_back(regs_q[32'(addr_q) + i][7:0]);
      end
    end else if (fc_q == FcWrite) begin
      if (32'(addr_q) >= NumRegs) return;
      regs_q[addr_q] = val_q;
      start_reply(tid_q, unit_q, WrRespLen);
      reply_bytes.push_back(FcWrite);
      reply_bytes.push_back(addr_q[15:8]);
      reply_bytes.push_back(addr_q[7:0]);
      reply_bytes.push_back(val_q[15:8]);
      reply_bytes.push_back(val_q[7:0]);
    end else begin
      return;
    end
    pack_reply();
  endfunction

  // model of one accepted request byte
  function automatic void take_byte(input logic [7:0] b, input logic fin);
    if (pos_q < FullLen) begin
      case (pos_q)
        4'd0:  tid_q[15:8] = b;
        4'd1:  tid_q[7:0] = b;
        4'd2:  proto_q[15:8] = b;
        4'd3:  proto_q[7:0] = b;
        4'd6:  unit_q = b;
        4'd7:  fc_q = b;
        4'd8:  addr_q[15:8] = b;
        4'd9:  addr_q[7:0] = b;
        4'd10: val_q[15:8] = b;
        4'd11: val_q[7:0] = b;
        default: ;
      endcase
      pos_q = pos_q + 4'd1;
    end
    if (fin) begin
      if (pos_q >= FullLen && proto_q == 16'h0000) answer_request();
      pos_q = '0;
    end
  endfunction

  // offer one byte, with random gaps, until it is accepted
  task automatic put_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    frame_end <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_byte(b, fin);
    bytes_sent++;
  endtask

  // send a whole frame and queue its expected response
  task automatic send_frame(input frame_t f);
    logic [7:0] hdr [12];
    hdr = '{f.tid[15:8], f.tid[7:0], f.proto[15:8], f.proto[7:0], 8'($urandom), 8'($urandom),
            f.unit, f.fc, f.addr[15:8], f.addr[7:0], f.val[15:8], f.val[7:0]};
    for (int i = 0; i < f.nb; i++) begin
      if (i < 12) put_byte(hdr[i], i == f.nb - 1);
      else put_byte(8'($urandom), i == f.nb - 1);
    end
    // hand-written expectations replace the model's reply
    if (f.kind != BY_MODEL) begin
      frame_pairs.delete();
      reply_bytes.delete();
      case (f.kind)
        ECHO_BACK: begin
          start_reply(f.tid, f.unit, WrRespLen);
          reply_bytes.push_back(FcWrite);
          reply_bytes.push_back(f.addr[15:8]);
          reply_bytes.push_back(f.addr[7:0]);
          reply_bytes.push_back(f.val[15:8]);
          reply_bytes.push_back(f.val[7:0]);
        end
        READ_BACK: begin
          start_reply(f.tid, f.unit, RdHdrLen + 16'(2 * f.val));
          reply_bytes.push_back(FcRead);
          reply_bytes.push_back(8'(2 * f.val));
          if (f.val > 0) begin
            reply_bytes.push_back(f.w0[15:8]);
            reply_bytes.push_back(f.w0[7:0]);
          end
          if (f.val > 1) begin
            reply_bytes.push_back(f.w1[15:8]);
            reply_bytes.push_back(f.w1[7:0]);
          end
        end
        default: ;
      endcase
      pack_reply();
    end
    while (frame_pairs.size() != 0) due_pairs.push_back(frame_pairs.pop_front());
    frames_sent++;
  endtask

  // random request, mostly well-formed with small reads
  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned room;
    int unsigned pick;
    f       = '0;
    f.kind  = BY_MODEL;
    f.tid   = 16'($urandom);
    f.unit  = 8'($urandom);
    f.proto = ($urandom_range(99) < 8) ? 16'($urandom_range(16'hFFFF, 1)) : 16'h0000;
    pick    = $urandom_range(99);
    f.fc    = (pick < 45) ? FcRead : (pick < 85) ? FcWrite : 8'($urandom);
    f.addr  = ($urandom_range(99) < 8) ? 16'($urandom) : 16'($urandom_range(NumRegs - 1));
    room    = (f.addr <= NumRegs) ? NumRegs - f.addr : 0;
    pick    = $urandom_range(99);
    if (f.fc != FcRead || pick < 10) f.val = 16'($urandom);
    else if (pick < 22) f.val = 16'($urandom_range(room));
    else f.val = 16'($urandom_range(room < 4 ? room : 4));
    pick = $urandom_range(99);
    f.nb = (pick < 85) ? 4'd12 : (pick < 92) ? 4'($urandom_range(15, 13))
                                             : 4'($urandom_range(11, 1));
    return f;
  endfunction

  // response side: random stall, compare each accepted pair with the oldest expectation
  always @(posedge clk) begin
    pair_t want;
    if (rst_ni && out_valid && !out_stall) begin
      pairs_seen++;
      if (last_flag) replies_seen++;
      if (due_pairs.size() == 0) begin
        $error("response pair %h %h with nothing expected", first_byte, second_byte);
        fails++;
      end else begin
        want = due_pairs.pop_front();
        if (first_byte !== want.fb) begin
          $error("first_byte: expected %h, got %h", want.fb, first_byte);
          fails++;
        end
        if (second_byte !== want.sb) begin
          $error("second_byte: expected %h, got %h", want.sb, second_byte);
          fails++;
        end
        if (valid_bytes !== want.nvalid) begin
          $error("valid_bytes: expected %0d, got %0d", want.nvalid, valid_bytes);
          fails++;
        end
        if (last_flag !== want.fin) begin
          $error("last: expected %0d, got %0d", want.fin, last_flag);
          fails++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // main sequence
  initial begin
    int unsigned waited;
    for (int i = 0; i < NumRegs; i++) regs_q[i] = '0;
    regs_q[0] = Reg0Reset;
    regs_q[1] = Reg1Reset;

    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed table, with a quiet stretch around the full file read where neither side idles
    foreach (plan[i]) begin
      gap_pct   = (i >= 1 && i < 6) ? 0 : 7;
      stall_pct = gap_pct;
      send_frame(plan[i]);
    end

    // random frames
    gap_pct   = 7;
    stall_pct = 7;
    while (bytes_sent < ByteTarget) begin
      send_frame(random_frame());
    end
    in_valid  <= 1'b0;

    // drain outstanding responses
    waited = 0;
    while (due_pairs.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (due_pairs.size() != 0) begin
      $error("%0d response pairs never arrived", due_pairs.size());
      fails++;
    end
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d request bytes in %0d frames (%0d directed)",
             bytes_sent, frames_sent, $size(plan));
    $display("checked %0d response pairs across %0d replies, %0d mismatches",
             pairs_seen, replies_seen, fails);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
